// ===== hw/rtl/fah_pkg.sv =====
// shared types, constants and helpers for the frost alarm level block
`timescale 1ns / 1ps

package fah_pkg;

   // configuration bus geometry
   localparam int unsigned PADDR_W = 5;
   localparam int unsigned PDATA_W = 32;

   // register map, one word each at byte address 4*index
   typedef enum logic [2:0] {
      REG_HIGH_PRESSURE  = 3'd0,
      REG_LOW_HUMIDITY   = 3'd1,
      REG_FROST_TEMP     = 3'd2,
      REG_CRITICAL_TEMP  = 3'd3,
      REG_EARLY_MIN_TEMP = 3'd4,
      REG_CRITICAL_SCORE = 3'd5,
      REG_EARLY_SCORE    = 3'd6,
      REG_HOLD_MINUTES   = 3'd7
   } reg_index_type;

   // alarm levels, ordered by severity
   typedef enum logic [1:0] {
      LEVEL_NORMAL   = 2'd0,
      LEVEL_EARLY    = 2'd1,
      LEVEL_CRITICAL = 2'd2,
      LEVEL_FROST    = 2'd3
   } level_type;

   // register reset values
   localparam logic [13:0] HIGH_PRESSURE_RST  = 14'd10200;
   localparam logic [9:0]  LOW_HUMIDITY_RST   = 10'd600;
   localparam logic [13:0] FROST_TEMP_RST     = 14'd0;
   localparam logic [13:0] CRITICAL_TEMP_RST  = 14'd200;
   localparam logic [14:0] EARLY_MIN_TEMP_RST = 15'd300;
   localparam logic [2:0]  CRITICAL_SCORE_RST = 3'd4;
   localparam logic [2:0]  EARLY_SCORE_RST    = 3'd2;
   localparam logic [10:0] HOLD_MINUTES_RST   = 11'd30;

   // value ranges
   localparam logic [13:0]        PRESSURE_MAX = 14'd12000;
   localparam logic [9:0]         HUMIDITY_MAX = 10'd1000;
   localparam logic signed [13:0] TEMP_MIN     = -14'sd4000;
   localparam logic signed [13:0] TEMP_MAX     = 14'sd6000;
   localparam logic signed [14:0] TMIN_MIN     = -15'sd10000;
   localparam logic signed [14:0] TMIN_MAX     = 15'sd6000;
   localparam logic [10:0]        HOLD_MAX     = 11'd1440;

   // fixed risk thresholds
   localparam logic signed [10:0] STABLE_DP_LIMIT = 11'sd10;
   localparam logic signed [13:0] STRONG_COOLING  = 14'sd100;
   localparam logic signed [13:0] CRITICAL_DEW    = 14'sd0;
   localparam logic signed [13:0] COLD_TEMP       = 14'sd400;

   // hold time in seconds: 1440 minutes * 60 fits in 17 bits
   localparam int unsigned HOLD_SECS_W = 17;

   typedef struct packed {
      logic [13:0] high_pressure;
      logic [9:0]  low_humidity;
      logic [13:0] frost_temp;
      logic [13:0] critical_temp;
      logic [14:0] early_min_temp;
      logic [2:0]  critical_score;
      logic [2:0]  early_score;
      logic [10:0] hold_minutes;
   } cfg_type;

   typedef struct packed {
      logic [13:0] pressure;
      logic [10:0] pressure_change;
      logic        pressure_change_valid;
      logic [9:0]  humidity;
      logic [13:0] cooling_rate;
      logic        cooling_rate_valid;
      logic [13:0] dew_point;
      logic [13:0] temperature;
      logic [14:0] min_temp_estimate;
      logic        min_temp_valid;
      logic [31:0] now_seconds;
   } req_item_type;

   typedef struct packed {
      level_type level;
      logic      pending;
   } level_stat_type;

   // clamp a 14 bit temperature to its range
   function automatic logic [13:0] sat_temp(input logic [13:0] v);
      logic [13:0] r;
      r = v;
      if ($signed(v) < TEMP_MIN) r = TEMP_MIN;
      if ($signed(v) > TEMP_MAX) r = TEMP_MAX;
      return r;
   endfunction

   // clamp a 15 bit projected minimum to its range
   function automatic logic [14:0] sat_tmin(input logic [14:0] v);
      logic [14:0] r;
      r = v;
      if ($signed(v) < TMIN_MIN) r = TMIN_MIN;
      if ($signed(v) > TMIN_MAX) r = TMIN_MAX;
      return r;
   endfunction

endpackage

// ===== hw/rtl/fah_req_if.sv =====
// input channel: one weather evaluation per transfer
`timescale 1ns / 1ps

interface fah_req_if;
   logic        valid;
   logic        ready;
   logic [13:0] pressure;
   logic [10:0] pressure_change;
   logic        pressure_change_valid;
   logic [9:0]  humidity;
   logic [13:0] cooling_rate;
   logic        cooling_rate_valid;
   logic [13:0] dew_point;
   logic [13:0] temperature;
   logic [14:0] min_temp_estimate;
   logic        min_temp_valid;
   logic [31:0] now_seconds;

   modport source (
      output valid, pressure, pressure_change, pressure_change_valid, humidity,
             cooling_rate, cooling_rate_valid, dew_point, temperature,
             min_temp_estimate, min_temp_valid, now_seconds,
      input  ready
   );

   modport sink (
      input  valid, pressure, pressure_change, pressure_change_valid, humidity,
             cooling_rate, cooling_rate_valid, dew_point, temperature,
             min_temp_estimate, min_temp_valid, now_seconds,
      output ready
   );
endinterface

// ===== hw/rtl/fah_rsp_if.sv =====
// result channel: score, alarm level and stepping-down flag per transfer
`timescale 1ns / 1ps

interface fah_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] risk_score;
   logic [1:0] alarm_level;
   logic       stepping_down;

   modport source (
      output valid, risk_score, alarm_level, stepping_down,
      input  ready
   );

   modport sink (
      input  valid, risk_score, alarm_level, stepping_down,
      output ready
   );
endinterface

// ===== hw/rtl/fah_csr.sv =====
// configuration register file with write-time range clamping
`timescale 1ns / 1ps

module fah_csr
   import fah_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign index  = reg_index_type'(paddr[PADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   // write decode with clamping to each register's range
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_HIGH_PRESSURE: begin
               cfg_in.high_pressure = (pwdata[13:0] > PRESSURE_MAX) ?
                                      PRESSURE_MAX : pwdata[13:0];
            end
            REG_LOW_HUMIDITY: begin
               cfg_in.low_humidity = (pwdata[9:0] > HUMIDITY_MAX) ?
                                     HUMIDITY_MAX : pwdata[9:0];
            end
            REG_FROST_TEMP:     cfg_in.frost_temp     = sat_temp(pwdata[13:0]);
            REG_CRITICAL_TEMP:  cfg_in.critical_temp  = sat_temp(pwdata[13:0]);
            REG_EARLY_MIN_TEMP: cfg_in.early_min_temp = sat_tmin(pwdata[14:0]);
            REG_CRITICAL_SCORE: cfg_in.critical_score = pwdata[2:0];
            REG_EARLY_SCORE:    cfg_in.early_score    = pwdata[2:0];
            REG_HOLD_MINUTES: begin
               cfg_in.hold_minutes = (pwdata[10:0] > HOLD_MAX) ?
                                     HOLD_MAX : pwdata[10:0];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_pressure  <= HIGH_PRESSURE_RST;
         cfg_ff.low_humidity   <= LOW_HUMIDITY_RST;
         cfg_ff.frost_temp     <= FROST_TEMP_RST;
         cfg_ff.critical_temp  <= CRITICAL_TEMP_RST;
         cfg_ff.early_min_temp <= EARLY_MIN_TEMP_RST;
         cfg_ff.critical_score <= CRITICAL_SCORE_RST;
         cfg_ff.early_score    <= EARLY_SCORE_RST;
         cfg_ff.hold_minutes   <= HOLD_MINUTES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, signed registers sign extended
   always_comb begin
      case (index)
         REG_HIGH_PRESSURE:  prdata = {18'd0, cfg_ff.high_pressure};
         REG_LOW_HUMIDITY:   prdata = {22'd0, cfg_ff.low_humidity};
         REG_FROST_TEMP:     prdata = {{18{cfg_ff.frost_temp[13]}}, cfg_ff.frost_temp};
         REG_CRITICAL_TEMP:  prdata = {{18{cfg_ff.critical_temp[13]}}, cfg_ff.critical_temp};
         REG_EARLY_MIN_TEMP: begin
            prdata = {{17{cfg_ff.early_min_temp[14]}}, cfg_ff.early_min_temp};
         end
         REG_CRITICAL_SCORE: prdata = {29'd0, cfg_ff.critical_score};
         REG_EARLY_SCORE:    prdata = {29'd0, cfg_ff.early_score};
         REG_HOLD_MINUTES:   prdata = {21'd0, cfg_ff.hold_minutes};
         default:            prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/fah_score.sv =====
// risk score and desired alarm level for one evaluation
`timescale 1ns / 1ps

module fah_score
   import fah_pkg::*;
(
   input  req_item_type item,
   input  cfg_type      cfg,
   output logic [2:0]   score,
   output level_type    want
);

   logic [13:0] pres;
   logic [9:0]  hum;
   logic [13:0] temp;
   logic [14:0] tmin;
   logic        stable_hit;
   logic        dry_hit;
   logic        cool_hit;
   logic        dew_hit;
   logic        cold_hit;

   // clamp fields whose range edge can flip a compare against a register
   assign pres = (item.pressure > PRESSURE_MAX) ? PRESSURE_MAX : item.pressure;
   assign hum  = (item.humidity > HUMIDITY_MAX) ? HUMIDITY_MAX : item.humidity;
   assign temp = sat_temp(item.temperature);
   assign tmin = sat_tmin(item.min_temp_estimate);

   // threshold tests; fixed limits lie well inside the field ranges
   assign stable_hit = item.pressure_change_valid && (pres > cfg.high_pressure) &&
                       ($signed(item.pressure_change) < STABLE_DP_LIMIT) &&
                       ($signed(item.pressure_change) > -STABLE_DP_LIMIT);
   assign dry_hit    = hum < cfg.low_humidity;
   assign cool_hit   = item.cooling_rate_valid &&
                       ($signed(item.cooling_rate) > STRONG_COOLING);
   assign dew_hit    = $signed(item.dew_point) <= CRITICAL_DEW;
   assign cold_hit   = $signed(temp) < COLD_TEMP;

   // weighted sum, at most 7
   assign score = {2'd0, stable_hit} + {2'd0, dry_hit} + {1'b0, cool_hit, 1'b0} +
                  {1'b0, dew_hit, 1'b0} + {2'd0, cold_hit};

   // desired level, most severe first
   always_comb begin
      if ($signed(temp) <= $signed(cfg.frost_temp)) begin
         want = LEVEL_FROST;
      end else if (score >= cfg.critical_score ||
                   $signed(temp) < $signed(cfg.critical_temp)) begin
         want = LEVEL_CRITICAL;
      end else if (score >= cfg.early_score ||
                   (item.min_temp_valid &&
                    $signed(tmin) < $signed(cfg.early_min_temp))) begin
         want = LEVEL_EARLY;
      end else begin
         want = LEVEL_NORMAL;
      end
   end

endmodule

// ===== hw/rtl/fah_level.sv =====
// alarm level with immediate rise and held descent
`timescale 1ns / 1ps

module fah_level
   import fah_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  level_type              want,
   input  logic [31:0]            now,
   input  logic [HOLD_SECS_W-1:0] hold_secs,
   output level_stat_type         stat
);

   level_type   level_ff;
   level_type   level_in;
   logic        pending_ff;
   logic        pending_in;
   logic [31:0] start_ff;
   logic [31:0] start_in;
   logic [31:0] elapsed;

   // next level, pending flag and descent start for the item in hand
   always_comb begin
      level_in   = level_ff;
      pending_in = 1'b0;
      start_in   = start_ff;
      elapsed    = '0;
      if (want >= level_ff) begin
         level_in = want;
      end else begin
         start_in   = pending_ff ? start_ff : now;
         elapsed    = now - start_in;
         pending_in = 1'b1;
         if (elapsed >= {{(32-HOLD_SECS_W){1'b0}}, hold_secs}) begin
            level_in   = want;
            pending_in = 1'b0;
         end
      end
   end

   assign stat.level   = level_in;
   assign stat.pending = pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= LEVEL_NORMAL;
         pending_ff <= 1'b0;
         start_ff   <= '0;
      end else if (step) begin
         level_ff   <= level_in;
         pending_ff <= pending_in;
         start_ff   <= start_in;
      end
   end

endmodule

// ===== hw/rtl/frost_alarm_level_hysteresis.sv =====
// top level of the frost alarm level block with hysteresis
// Use: each transfer on req_chan carries one weather evaluation (pressure, six
// hour change, humidity, cooling rate, dew point, temperature, projected
// minimum, validity flags and a time stamp in seconds). For each one the block
// returns one transfer on rsp_chan: risk score 0..7, alarm level and a flag
// that is set while a lower level waits out the hold time.
// An item taken on req_chan sits in the input register, and its result loads
// into the output register. Throughput is one item per cycle while rsp_chan
// takes results, set by the single evaluation stage between the input and
// output registers; the level state updates as each result loads.
// When rsp_chan stalls the output register holds its result and the input
// register still takes one more item; req_chan.ready drops only when both are
// full. Configuration goes through the APB-style port, one register per word
// at byte address 4*index, values clamped to their range as written; write it
// only while no item is in flight.
// Reset (synchronous, active high) empties both registers, sets the level to
// normal with no descent pending and loads the register defaults.
`timescale 1ns / 1ps

module frost_alarm_level_hysteresis
   import fah_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   fah_req_if.sink            req_chan,
   fah_rsp_if.source          rsp_chan,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   cfg_type                cfg;
   req_item_type           item;
   req_item_type           s1_item_ff;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [2:0]             score_ff;
   logic [1:0]             level_out_ff;
   logic                   pending_out_ff;
   logic                   advance;
   logic                   req_xfer;
   logic                   step;
   logic [2:0]             score;
   level_type              want;
   level_stat_type         stat;
   logic [HOLD_SECS_W-1:0] hold_secs;

   fah_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // gather the input transfer
   assign item.pressure              = req_chan.pressure;
   assign item.pressure_change       = req_chan.pressure_change;
   assign item.pressure_change_valid = req_chan.pressure_change_valid;
   assign item.humidity              = req_chan.humidity;
   assign item.cooling_rate          = req_chan.cooling_rate;
   assign item.cooling_rate_valid    = req_chan.cooling_rate_valid;
   assign item.dew_point             = req_chan.dew_point;
   assign item.temperature           = req_chan.temperature;
   assign item.min_temp_estimate     = req_chan.min_temp_estimate;
   assign item.min_temp_valid        = req_chan.min_temp_valid;
   assign item.now_seconds           = req_chan.now_seconds;

   // handshake between the two registers
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign step           = s1_valid_ff && advance;
   assign s1_valid_in    = req_xfer || (s1_valid_ff && !advance);
   assign rsp_valid_in   = step || (rsp_valid_ff && !rsp_chan.ready);

   // hold time in seconds: minutes * 64 - minutes * 4
   assign hold_secs = ({{(HOLD_SECS_W-11){1'b0}}, cfg.hold_minutes} << 6) -
                      ({{(HOLD_SECS_W-11){1'b0}}, cfg.hold_minutes} << 2);

   fah_score u_score (
      .item  (s1_item_ff),
      .cfg   (cfg),
      .score (score),
      .want  (want)
   );

   fah_level u_level (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .want      (want),
      .now       (s1_item_ff.now_seconds),
      .hold_secs (hold_secs),
      .stat      (stat)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff <= item;
      end
      if (step) begin
         score_ff       <= score;
         level_out_ff   <= stat.level;
         pending_out_ff <= stat.pending;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.risk_score    = score_ff;
   assign rsp_chan.alarm_level   = level_out_ff;
   assign rsp_chan.stepping_down = pending_out_ff;

endmodule

// ===== sim/tb_frost_alarm_level_hysteresis.sv =====
// self-checking testbench for the frost alarm level block with hysteresis
`timescale 1ns / 1ps

module tb_frost_alarm_level_hysteresis;
   import fah_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int ITEM_W     = $bits(req_item_type);

   typedef struct packed {
      logic [2:0] score;
      level_type  level;
      logic       pending;
   } alarm_result_type;

   logic               clock;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   fah_req_if req_chan ();
   fah_rsp_if rsp_chan ();

   frost_alarm_level_hysteresis i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor copy of the registers and level state
   int          hp_cfg = 10200;
   int          hum_cfg = 600;
   int          frost_cfg = 0;
   int          crit_cfg = 200;
   int          early_min_cfg = 300;
   int          crit_score_cfg = 4;
   int          early_score_cfg = 2;
   int          hold_cfg = 30;
   level_type   level_now = LEVEL_NORMAL;
   logic        descent_on = 1'b0;
   logic [31:0] descent_t0 = '0;

   alarm_result_type alarm_q[$];
   int               fail_count = 0;
   int               idle_cycles = 0;
   logic [31:0]      wall_s = '0;

   // idling controls shared by sender and receiver
   int sender_gap_pct = 20;
   int rsp_stall_pct = 20;
   bit hold_off_req = 1'b0;
   int hold_off_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int rnd(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic int near(int center, int spread, int lo, int hi);
      return clamp(center + rnd(-spread, spread), lo, hi);
   endfunction

   // gap length: mostly short, now and then long
   function automatic int idle_len();
      return (rnd(0, 9) == 0) ? rnd(8, 40) : rnd(1, 3);
   endfunction

   function automatic int pick_gap();
      return (rnd(0, 99) < sender_gap_pct) ? idle_len() : 0;
   endfunction

   // register write as the block stores it: low field bits, then clamp
   function automatic void apply_reg(reg_index_type idx, logic [31:0] v);
      case (idx)
         REG_HIGH_PRESSURE:  hp_cfg = clamp(int'(v[13:0]), 0, 12000);
         REG_LOW_HUMIDITY:   hum_cfg = clamp(int'(v[9:0]), 0, 1000);
         REG_FROST_TEMP:     frost_cfg = clamp(int'($signed(v[13:0])), -4000, 6000);
         REG_CRITICAL_TEMP:  crit_cfg = clamp(int'($signed(v[13:0])), -4000, 6000);
         REG_EARLY_MIN_TEMP: early_min_cfg = clamp(int'($signed(v[14:0])), -10000, 6000);
         REG_CRITICAL_SCORE: crit_score_cfg = int'(v[2:0]);
         REG_EARLY_SCORE:    early_score_cfg = int'(v[2:0]);
         REG_HOLD_MINUTES:   hold_cfg = clamp(int'(v[10:0]), 0, 1440);
         default: ;
      endcase
   endfunction

   // score, wanted level and hold-time step-down for one evaluation
   function automatic alarm_result_type predict_alarm(req_item_type it);
      int               pres;
      int               chg;
      int               hum;
      int               cool;
      int               dew;
      int               temp;
      int               tmin;
      int               score;
      level_type        want;
      logic [31:0]      elapsed;
      alarm_result_type r;
      pres = clamp(int'(it.pressure), 0, 12000);
      chg  = clamp(int'($signed(it.pressure_change)), -1000, 1000);
      hum  = clamp(int'(it.humidity), 0, 1000);
      cool = clamp(int'($signed(it.cooling_rate)), -5000, 5000);
      dew  = clamp(int'($signed(it.dew_point)), -6000, 6000);
      temp = clamp(int'($signed(it.temperature)), -4000, 6000);
      tmin = clamp(int'($signed(it.min_temp_estimate)), -10000, 6000);
      score = 0;
      if (it.pressure_change_valid && pres > hp_cfg && chg > -10 && chg < 10) score += 1;
      if (hum < hum_cfg) score += 1;
      if (it.cooling_rate_valid && cool > 100) score += 2;
      if (dew <= 0) score += 2;
      if (temp < 400) score += 1;
      if (temp <= frost_cfg) begin
         want = LEVEL_FROST;
      end else if (score >= crit_score_cfg || temp < crit_cfg) begin
         want = LEVEL_CRITICAL;
      end else if (score >= early_score_cfg || (it.min_temp_valid && tmin < early_min_cfg)) begin
         want = LEVEL_EARLY;
      end else begin
         want = LEVEL_NORMAL;
      end
      if (want >= level_now) begin
         level_now = want;
         descent_on = 1'b0;
      end else begin
         if (!descent_on) begin
            descent_on = 1'b1;
            descent_t0 = it.now_seconds;
         end
         elapsed = it.now_seconds - descent_t0;
         if (elapsed >= 32'(hold_cfg * 60)) begin
            level_now = want;
            descent_on = 1'b0;
         end
      end
      r.score = score[2:0];
      r.level = level_now;
      r.pending = descent_on;
      return r;
   endfunction

   // benign evaluation that wants normal level under the default registers
   function automatic req_item_type calm_item(logic [31:0] stamp);
      req_item_type it;
      it = '0;
      it.pressure = 14'd10000;
      it.humidity = 10'd800;
      it.dew_point = 14'd500;
      it.temperature = 14'd1500;
      it.min_temp_estimate = 15'd1000;
      it.now_seconds = stamp;
      return it;
   endfunction

   // time stamps: small steps, steps scaled to the hold time, rare jumps
   function automatic logic [31:0] next_stamp();
      int pick;
      int hold_s;
      pick = rnd(0, 99);
      hold_s = hold_cfg * 60;
      if (pick < 3) wall_s = $urandom();
      else if (pick < 35) wall_s += 32'(rnd(0, 30));
      else if (pick < 90) wall_s += 32'(rnd(0, hold_s / 4 + 60));
      else wall_s += 32'(hold_s + rnd(-1, 1));
      return wall_s;
   endfunction

   // weather item biased toward the thresholds, regime picks the temperature band
   function automatic req_item_type random_item(int regime);
      req_item_type it;
      if (rnd(0, 7) == 0) begin
         it = ITEM_W'({$urandom(), $urandom(), $urandom(), $urandom()});
         it.now_seconds = next_stamp();
         return it;
      end
      it.pressure = 14'(rnd(0, 1) ? near(hp_cfg, 20, 0, 12000) : rnd(0, 12000));
      it.pressure_change = 11'(rnd(0, 1) ? rnd(-20, 20) : rnd(-1000, 1000));
      it.pressure_change_valid = 1'(rnd(0, 1));
      it.humidity = 10'(rnd(0, 1) ? near(hum_cfg, 30, 0, 1000) : rnd(0, 1000));
      it.cooling_rate = 14'(rnd(0, 1) ? rnd(50, 150) : rnd(-5000, 5000));
      it.cooling_rate_valid = 1'(rnd(0, 1));
      if (regime == 0) it.dew_point = 14'(rnd(1, 6000));
      else it.dew_point = 14'(rnd(0, 1) ? rnd(-50, 50) : rnd(-6000, 6000));
      case (regime)
         0: it.temperature = 14'(rnd(400, 6000));
         1: it.temperature = 14'(near(crit_cfg, 150, -4000, 6000));
         2: it.temperature = 14'(near(frost_cfg, 150, -4000, 6000));
         default: it.temperature = 14'(rnd(-4000, 6000));
      endcase
      it.min_temp_estimate = 15'(rnd(0, 1) ? near(early_min_cfg, 100, -10000, 6000)
                                           : rnd(-10000, 6000));
      it.min_temp_valid = 1'(rnd(0, 1));
      it.now_seconds = next_stamp();
      return it;
   endfunction

   task automatic drive_fields(input req_item_type it);
      req_chan.pressure <= it.pressure;
      req_chan.pressure_change <= it.pressure_change;
      req_chan.pressure_change_valid <= it.pressure_change_valid;
      req_chan.humidity <= it.humidity;
      req_chan.cooling_rate <= it.cooling_rate;
      req_chan.cooling_rate_valid <= it.cooling_rate_valid;
      req_chan.dew_point <= it.dew_point;
      req_chan.temperature <= it.temperature;
      req_chan.min_temp_estimate <= it.min_temp_estimate;
      req_chan.min_temp_valid <= it.min_temp_valid;
      req_chan.now_seconds <= it.now_seconds;
   endtask

   // offer one item, predict on transfer, then idle for the given gap
   task automatic send_item(input req_item_type it, input int gap);
      req_chan.valid <= 1'b1;
      drive_fields(it);
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      alarm_q.push_back(predict_alarm(it));
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and let every expected result drain
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (alarm_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // setup cycle, access cycle, then release the bus
   task automatic write_reg(input reg_index_type idx, input logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_W'({idx, 2'b00});
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      apply_reg(idx, v);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [31:0] hp, input logic [31:0] hum,
                               input logic [31:0] frost, input logic [31:0] crit,
                               input logic [31:0] early_min, input logic [31:0] cs,
                               input logic [31:0] es, input logic [31:0] hold);
      wait_idle();
      write_reg(REG_HIGH_PRESSURE, hp);
      write_reg(REG_LOW_HUMIDITY, hum);
      write_reg(REG_FROST_TEMP, frost);
      write_reg(REG_CRITICAL_TEMP, crit);
      write_reg(REG_EARLY_MIN_TEMP, early_min);
      write_reg(REG_CRITICAL_SCORE, cs);
      write_reg(REG_EARLY_SCORE, es);
      write_reg(REG_HOLD_MINUTES, hold);
   endtask

   // bursts of one weather regime so levels persist and descents complete
   task automatic run_random(input int count);
      int n;
      int regime;
      int burst_left;
      regime = 0;
      burst_left = 0;
      for (n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            regime = rnd(0, 3);
            burst_left = rnd(3, 40);
         end
         burst_left--;
         send_item(random_item(regime), pick_gap());
      end
   endtask

   // directed items under the reset register values
   task automatic test_default_levels();
      req_item_type it;
      send_item(calm_item(32'd0), pick_gap());
      // every score term at its limit, score seven
      it = calm_item(32'd10);
      it.pressure = 14'd12000;
      it.pressure_change = 11'd9;
      it.pressure_change_valid = 1'b1;
      it.humidity = 10'd0;
      it.cooling_rate = 14'd101;
      it.cooling_rate_valid = 1'b1;
      it.dew_point = 14'd0;
      it.temperature = 14'd399;
      send_item(it, pick_gap());
      // every score term just missed, early from projected minimum
      it = calm_item(32'd20);
      it.pressure = 14'd10200;
      it.pressure_change = -11'sd10;
      it.pressure_change_valid = 1'b1;
      it.humidity = 10'd600;
      it.cooling_rate = 14'd100;
      it.cooling_rate_valid = 1'b1;
      it.dew_point = 14'd1;
      it.temperature = 14'd400;
      it.min_temp_estimate = 15'd299;
      it.min_temp_valid = 1'b1;
      send_item(it, pick_gap());
      // frost forced at the temperature limit
      it = calm_item(32'd30);
      it.temperature = 14'd0;
      send_item(it, pick_gap());
      // raw fields below range
      it.pressure = 14'd0;
      it.pressure_change = 11'h400;
      it.pressure_change_valid = 1'b1;
      it.humidity = 10'd0;
      it.cooling_rate = 14'h2000;
      it.cooling_rate_valid = 1'b1;
      it.dew_point = 14'h2000;
      it.temperature = 14'h2000;
      it.min_temp_estimate = 15'h4000;
      it.min_temp_valid = 1'b1;
      it.now_seconds = 32'd40;
      send_item(it, pick_gap());
      // raw fields above range, starts a descent from frost
      it.pressure = 14'h3fff;
      it.pressure_change = 11'h3ff;
      it.humidity = 10'h3ff;
      it.cooling_rate = 14'h1fff;
      it.dew_point = 14'h1fff;
      it.temperature = 14'h1fff;
      it.min_temp_estimate = 15'h3fff;
      it.now_seconds = 32'd50;
      send_item(it, pick_gap());
      // one second short of the hold time, then exactly on it
      send_item(calm_item(32'd1849), pick_gap());
      send_item(calm_item(32'd1850), pick_gap());
      // critical from temperature alone, then a time stamp that steps back
      it = calm_item(32'd1900);
      it.temperature = 14'd199;
      send_item(it, pick_gap());
      it = calm_item(32'd1910);
      it.temperature = 14'd200;
      send_item(it, pick_gap());
      send_item(calm_item(32'd100), pick_gap());
      // early from score, then a descent across the time stamp wrap
      it = calm_item(32'd200);
      it.humidity = 10'd599;
      it.temperature = 14'd399;
      send_item(it, pick_gap());
      send_item(calm_item(32'hffff_fff0), pick_gap());
      send_item(calm_item(32'h0000_0700), pick_gap());
      // invalid change and cooling flags hide their terms
      it = calm_item(32'h0000_0800);
      it.pressure = 14'd12000;
      it.cooling_rate = 14'd5000;
      send_item(it, pick_gap());
      it.pressure = 14'd10201;
      it.pressure_change = -11'sd9;
      it.pressure_change_valid = 1'b1;
      it.dew_point = -14'sd1;
      send_item(it, pick_gap());
      send_item(calm_item(32'hffff_ffff), pick_gap());
      run_random(250);
   endtask

   // minimum thresholds and zero hold time
   task automatic test_zero_thresholds();
      req_item_type it;
      program_regs(32'd0, 32'd0, 32'(-4000), 32'(-4000), 32'(-10000), 32'd0, 32'd0, 32'd0);
      it = calm_item(32'd500);
      it.temperature = -14'sd4000;
      send_item(it, pick_gap());
      // zero hold: the lower level applies on the same item
      it.temperature = 14'd1500;
      send_item(it, pick_gap());
      run_random(250);
   endtask

   // maximum thresholds, written through raw out-of-range words
   task automatic test_max_thresholds();
      program_regs(32'hffff_ffff, 32'h0000_03ff, 32'h0000_1fff, 32'd6000,
                   32'h0000_3fff, 32'd7, 32'hffff_ffff, 32'h0000_07ff);
      run_random(100);
   endtask

   // several random register settings, the first with no idling at all
   task automatic test_random_settings();
      int round;
      for (round = 0; round < 4; round++) begin
         program_regs(rnd(0, 4) == 0 ? $urandom() : 32'(rnd(0, 12000)),
                      rnd(0, 4) == 0 ? $urandom() : 32'(rnd(0, 1000)),
                      32'(rnd(-4000, 2000)),
                      32'(rnd(-4000, 6000)),
                      rnd(0, 4) == 0 ? $urandom() : 32'(rnd(-10000, 6000)),
                      $urandom(),
                      $urandom(),
                      rnd(0, 4) == 0 ? $urandom() : 32'(rnd(0, 60)));
         sender_gap_pct = (round == 0) ? 0 : rnd(10, 40);
         rsp_stall_pct = (round == 0) ? 0 : rnd(10, 40);
         run_random(200);
      end
      sender_gap_pct = 20;
      rsp_stall_pct = 20;
   endtask

   // receiver holds off long while the sender keeps offering
   task automatic test_output_hold_off();
      int n;
      hold_off_cycles = 300;
      hold_off_req = 1'b1;
      for (n = 0; n < 40; n++) send_item(random_item(rnd(0, 3)), 0);
      wait_idle();
   endtask

   // result side ready, with random stalls and a long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (rnd(0, 99) < rsp_stall_pct) begin
            rsp_chan.ready <= 1'b0;
            stall_left = idle_len() - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      alarm_result_type want_r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (alarm_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("%0t: result transfer with nothing expected", $time);
         end else begin
            want_r = alarm_q.pop_front();
            if (rsp_chan.risk_score !== want_r.score || rsp_chan.alarm_level !== want_r.level ||
                rsp_chan.stepping_down !== want_r.pending) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: expected score %0d level %0d down %0b, got %0d %0d %0b",
                           $time, want_r.score, want_r.level, want_r.pending,
                           rsp_chan.risk_score, rsp_chan.alarm_level, rsp_chan.stepping_down);
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_chan.valid <= 1'b0;
      drive_fields('0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_default_levels();
      test_zero_thresholds();
      test_max_thresholds();
      test_random_settings();
      test_output_hold_off();
      wait_idle();
      if (fail_count == 0 && alarm_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
